// ----- hw/rtl/gbn_pkg.sv -----
package gbn_pkg;

    // Event codes on the input channel
    typedef enum logic [2:0] {
        OP_PACKET   = 3'd0,
        OP_LINE     = 3'd1,
        OP_FRAME    = 3'd2,
        OP_DATA_TMO = 3'd3,
        OP_ACK_TMO  = 3'd4
    } op_t;

    // Kind of a received frame
    localparam logic [1:0] RX_DATA = 2'd0;
    localparam logic [1:0] RX_ACK  = 2'd1;
    localparam logic [1:0] RX_NAK  = 2'd2;

    // Kind of a result beat
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_DATA = 2'd1,
        KIND_ACK  = 2'd2,
        KIND_NAK  = 2'd3
    } send_kind_t;

    // Ack timer command
    typedef enum logic [1:0] {
        ATC_LEAVE = 2'd0,
        ATC_START = 2'd1,
        ATC_STOP  = 2'd2
    } atc_t;

    // Frames emitted per event at most
    localparam int MAX_FRAMES  = 7;
    localparam int FRAME_CNT_W = 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_WALK,
        ST_RX,
        ST_FRAME,
        ST_RESEND,
        ST_STATUS
    } state_t;

    typedef struct packed {
        logic       load;
        logic       pkt_prep;
        logic       line_set;
        logic       walk_step;
        logic       rx_deliver;
        logic       ack_start;
        logic       resend_init;
        logic       resend_step;
        logic       emit;
        send_kind_t emit_kind;
    } gbn_cmd_t;

    typedef struct packed {
        op_t        op;
        logic       frame_good;
        logic [1:0] frame_kind;
        logic       window_full;
        logic       nak_allowed;
        logic       walk_more;
        logic       nak_in_window;
        logic       seq_match;
        logic       resend_more;
        logic       out_free;
    } gbn_stat_t;

    typedef struct packed {
        send_kind_t send_kind;
        logic [2:0] send_seq;
        logic [2:0] send_ack;
        logic       start_data_timer;
        logic [7:0] stopped_timers;
        atc_t       ack_timer_cmd;
        logic       deliver_packet;
        logic       network_enable;
        logic       last;
    } gbn_result_t;

endpackage

// ----- hw/rtl/gbn_ctrl.sv -----
module gbn_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  gbn_pkg::gbn_stat_t stat,
    output gbn_pkg::gbn_cmd_t  cmd
);
    import gbn_pkg::*;

    state_t     state_reg, state_next;
    send_kind_t frame_kind_reg, frame_kind_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            frame_kind_reg <= KIND_NONE;
        end else begin
            state_reg      <= state_next;
            frame_kind_reg <= frame_kind_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        frame_kind_next = frame_kind_reg;
        cmd             = '0;
        cmd.emit_kind   = KIND_NONE;
        s_tready        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                state_next = ST_STATUS;
                case (stat.op)
                    OP_PACKET: begin
                        if (!stat.window_full) begin
                            cmd.pkt_prep    = 1'b1;
                            frame_kind_next = KIND_DATA;
                            state_next      = ST_FRAME;
                        end
                    end
                    OP_LINE: cmd.line_set = 1'b1;
                    OP_FRAME: begin
                        if (!stat.frame_good) begin
                            if (stat.nak_allowed) begin
                                frame_kind_next = KIND_NAK;
                                state_next      = ST_FRAME;
                            end
                        end else begin
                            state_next = ST_WALK;
                        end
                    end
                    OP_DATA_TMO: begin
                        cmd.resend_init = 1'b1;
                        state_next      = ST_RESEND;
                    end
                    OP_ACK_TMO: begin
                        frame_kind_next = KIND_ACK;
                        state_next      = ST_FRAME;
                    end
                    default: state_next = ST_STATUS;
                endcase
            end
            ST_WALK: begin
                // advance the window one slot per cycle up to the cumulative ack
                if (stat.walk_more) begin
                    cmd.walk_step = 1'b1;
                end else begin
                    state_next = ST_RX;
                end
            end
            ST_RX: begin
                state_next = ST_STATUS;
                if (stat.frame_kind == RX_DATA) begin
                    if (stat.seq_match) begin
                        cmd.rx_deliver = 1'b1;
                    end else if (stat.nak_allowed) begin
                        frame_kind_next = KIND_NAK;
                        state_next      = ST_FRAME;
                    end else begin
                        cmd.ack_start = 1'b1;
                    end
                end else if (stat.frame_kind == RX_NAK && stat.nak_in_window) begin
                    cmd.resend_init = 1'b1;
                    state_next      = ST_RESEND;
                end
            end
            ST_FRAME: begin
                if (stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = frame_kind_reg;
                    state_next    = ST_STATUS;
                end
            end
            ST_RESEND: begin
                if (!stat.resend_more) begin
                    state_next = ST_STATUS;
                end else if (stat.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_kind   = KIND_DATA;
                    cmd.resend_step = 1'b1;
                end
            end
            ST_STATUS: begin
                if (stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_NONE;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- hw/rtl/gbn_datapath.sv -----
module gbn_datapath #(
    parameter int MAX_SEQUENCE = 7
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [2:0]           in_operation,
    input  logic                 in_frame_good,
    input  logic [1:0]           in_frame_kind,
    input  logic [2:0]           in_frame_seq,
    input  logic [2:0]           in_cum_ack,
    input  gbn_pkg::gbn_cmd_t    cmd,
    output gbn_pkg::gbn_stat_t   stat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output gbn_pkg::gbn_result_t out_result
);
    import gbn_pkg::*;

    localparam int SEQ_W = (MAX_SEQUENCE < 2) ? 1 : $clog2(MAX_SEQUENCE + 1);
    localparam logic [SEQ_W-1:0] SEQ_MAX  = SEQ_W'(MAX_SEQUENCE);
    localparam logic [SEQ_W:0]   SEQ_MODV = (SEQ_W + 1)'(MAX_SEQUENCE + 1);

    function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] v);
        return (v == SEQ_MAX) ? '0 : v + SEQ_W'(1);
    endfunction

    function automatic logic [SEQ_W-1:0] seq_add(input logic [SEQ_W-1:0] a,
                                                 input logic [SEQ_W-1:0] b);
        logic [SEQ_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= SEQ_MODV) s = s - SEQ_MODV;
        return s[SEQ_W-1:0];
    endfunction

    // fold a 3-bit received number into the sequence space
    function automatic logic [SEQ_W-1:0] seq_fold(input logic [2:0] v);
        logic [7:0] r;
        r = {5'b0, v};
        for (int i = 0; i < 7; i++) begin
            if (r >= 8'(MAX_SEQUENCE + 1)) r = r - 8'(MAX_SEQUENCE + 1);
        end
        return SEQ_W'(r);
    endfunction

    function automatic logic in_win(input logic [SEQ_W-1:0] a,
                                    input logic [SEQ_W-1:0] b,
                                    input logic [SEQ_W-1:0] c);
        return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
    endfunction

    // link state
    logic [SEQ_W-1:0] wl_reg, wl_next;
    logic [SEQ_W-1:0] ns_reg, ns_next;
    logic [SEQ_W-1:0] exp_reg, exp_next;
    logic [SEQ_W-1:0] bc_reg, bc_next;
    logic             nak_reg, nak_next;
    logic             lr_reg, lr_next;

    // per-event registers
    op_t              op_reg, op_next;
    logic             good_reg, good_next;
    logic [1:0]       kind_reg, kind_next;
    logic [SEQ_W-1:0] fseq_reg, fseq_next;
    logic [SEQ_W-1:0] fack_reg, fack_next;
    logic [SEQ_W-1:0] cursor_reg, cursor_next;
    logic [FRAME_CNT_W-1:0] remain_reg, remain_next;
    logic [7:0]       mask_reg, mask_next;
    atc_t             atc_reg, atc_next;
    logic             dlv_reg, dlv_next;
    logic             first_reg, first_next;

    // result register
    logic             out_valid_reg, out_valid_next;
    gbn_result_t      res_reg, res_next;

    logic [SEQ_W-1:0] ack_field;

    assign ack_field = (exp_reg == '0) ? SEQ_MAX : exp_reg - SEQ_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wl_reg        <= '0;
            ns_reg        <= '0;
            exp_reg       <= '0;
            bc_reg        <= '0;
            nak_reg       <= 1'b1;
            lr_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            wl_reg        <= wl_next;
            ns_reg        <= ns_next;
            exp_reg       <= exp_next;
            bc_reg        <= bc_next;
            nak_reg       <= nak_next;
            lr_reg        <= lr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        good_reg   <= good_next;
        kind_reg   <= kind_next;
        fseq_reg   <= fseq_next;
        fack_reg   <= fack_next;
        cursor_reg <= cursor_next;
        remain_reg <= remain_next;
        mask_reg   <= mask_next;
        atc_reg    <= atc_next;
        dlv_reg    <= dlv_next;
        first_reg  <= first_next;
        res_reg    <= res_next;
    end

    always_comb begin
        wl_next        = wl_reg;
        ns_next        = ns_reg;
        exp_next       = exp_reg;
        bc_next        = bc_reg;
        nak_next       = nak_reg;
        lr_next        = lr_reg;
        op_next        = op_reg;
        good_next      = good_reg;
        kind_next      = kind_reg;
        fseq_next      = fseq_reg;
        fack_next      = fack_reg;
        cursor_next    = cursor_reg;
        remain_next    = remain_reg;
        mask_next      = mask_reg;
        atc_next       = atc_reg;
        dlv_next       = dlv_reg;
        first_next     = first_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cmd.load) begin
            op_next    = op_t'(in_operation);
            good_next  = in_frame_good;
            kind_next  = in_frame_kind;
            fseq_next  = seq_fold(in_frame_seq);
            fack_next  = seq_fold(in_cum_ack);
            mask_next  = '0;
            atc_next   = ATC_LEAVE;
            dlv_next   = 1'b0;
            first_next = 1'b1;
        end

        if (cmd.pkt_prep) begin
            cursor_next = ns_reg;
            ns_next     = seq_inc(ns_reg);
            bc_next     = bc_reg + SEQ_W'(1);
        end

        if (cmd.line_set) lr_next = 1'b1;

        if (cmd.walk_step) begin
            if (bc_reg != '0) bc_next = bc_reg - SEQ_W'(1);
            for (int i = 0; i < 8; i++) begin
                if (int'(wl_reg) == i) mask_next[i] = 1'b1;
            end
            wl_next = seq_inc(wl_reg);
        end

        if (cmd.rx_deliver) begin
            dlv_next = 1'b1;
            nak_next = 1'b1;
            exp_next = seq_inc(exp_reg);
            atc_next = ATC_START;
        end

        if (cmd.ack_start) atc_next = ATC_START;

        if (cmd.resend_init) begin
            cursor_next = wl_reg;
            ns_next     = seq_add(wl_reg, bc_reg);
            if (int'(bc_reg) > MAX_FRAMES) begin
                remain_next = FRAME_CNT_W'(MAX_FRAMES);
            end else begin
                remain_next = FRAME_CNT_W'(bc_reg);
            end
        end

        if (cmd.resend_step) begin
            cursor_next = seq_inc(cursor_reg);
            remain_next = remain_reg - FRAME_CNT_W'(1);
        end

        if (cmd.emit) begin
            out_valid_next          = 1'b1;
            first_next              = 1'b0;
            res_next.send_kind      = cmd.emit_kind;
            res_next.send_seq       = '0;
            res_next.send_ack       = 3'(ack_field);
            res_next.start_data_timer = 1'b0;
            res_next.stopped_timers = first_reg ? mask_reg : 8'h00;
            res_next.ack_timer_cmd  = ATC_STOP;
            res_next.deliver_packet = 1'b0;
            res_next.network_enable = 1'b0;
            res_next.last           = 1'b0;
            case (cmd.emit_kind)
                KIND_DATA: begin
                    res_next.send_seq         = 3'(cursor_reg);
                    res_next.start_data_timer = 1'b1;
                    lr_next                   = 1'b0;
                end
                KIND_ACK: lr_next = 1'b0;
                KIND_NAK: begin
                    nak_next = 1'b0;
                    lr_next  = 1'b0;
                end
                default: begin
                    res_next.send_ack       = '0;
                    res_next.ack_timer_cmd  = atc_reg;
                    res_next.deliver_packet = dlv_reg;
                    res_next.network_enable = (bc_reg != SEQ_MAX) && lr_reg;
                    res_next.last           = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        stat.op            = op_reg;
        stat.frame_good    = good_reg;
        stat.frame_kind    = kind_reg;
        stat.window_full   = (bc_reg == SEQ_MAX);
        stat.nak_allowed   = nak_reg;
        stat.walk_more     = in_win(wl_reg, fack_reg, ns_reg);
        stat.nak_in_window = in_win(wl_reg, seq_inc(fack_reg), ns_reg);
        stat.seq_match     = (fseq_reg == exp_reg);
        stat.resend_more   = (remain_reg != '0);
        stat.out_free      = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = res_reg;

endmodule

// ----- hw/rtl/go_back_n_link_control_core.sv -----
// Channel | Dir | tdata fields (low bit up)                         | tuser                 | tlast
// s_      | in  | frame_good, frame_seq, cum_ack                    | operation, frame_kind | -
// m_      | out | send_seq, send_ack, start_data_timer,              | send_kind             | last
//         |     | stopped_timers, ack_timer_cmd, deliver_packet,     |                       |
//         |     | network_enable                                     |                       |
//
// One event at a time: the core accepts an event, decodes it, then emits its result beats.
// A good received frame first walks the window one slot per cycle up to its cumulative ack,
// then takes its receive decision; a retransmission, by timeout or by an in-window NAK,
// leaves its resend state after its last data beat and then emits the status beat.
// Reset (aresetn low, synchronous) empties the window and the result register.
// m_tready low holds the result register and stalls the event in progress.
module go_back_n_link_control_core #(
    parameter int MAX_SEQUENCE = 7
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] frame_good, [3:1] frame_seq, [6:4] cum_ack, [7] zero
    input  logic [7:0]  s_tdata,
    // [2:0] operation, [4:3] frame_kind
    input  logic [4:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] send_seq, [5:3] send_ack, [6] start_data_timer, [14:7] stopped_timers,
    // [16:15] ack_timer_cmd, [17] deliver_packet, [18] network_enable, [23:19] zero
    output logic [23:0] m_tdata,
    // [1:0] send_kind
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);
    import gbn_pkg::*;

    gbn_cmd_t    cmd;
    gbn_stat_t   stat;
    gbn_result_t res;

    // sequencer: decode the event, walk the ack, pace the frame beats
    gbn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // window edges, receive state and the result register
    gbn_datapath #(
        .MAX_SEQUENCE (MAX_SEQUENCE)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_operation  (s_tuser[2:0]),
        .in_frame_good (s_tdata[0]),
        .in_frame_kind (s_tuser[4:3]),
        .in_frame_seq  (s_tdata[3:1]),
        .in_cum_ack    (s_tdata[6:4]),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_result    (res)
    );

    // pack the result beat
    assign m_tdata = {5'b0, res.network_enable, res.deliver_packet, res.ack_timer_cmd,
                      res.stopped_timers, res.start_data_timer, res.send_ack, res.send_seq};
    assign m_tuser = res.send_kind;
    assign m_tlast = res.last;

    // one event in flight: an accepted beat closes the input side
    a_one_event: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an event is in flight");

    // only the status beat closes an event
    a_last_is_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tuser == KIND_NONE))
        else $error("last set on a frame beat");

    // every data frame beat starts its retransmit timer and stops the ack timer
    a_data_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_DATA) |-> (m_tdata[6] && m_tdata[16:15] == ATC_STOP))
        else $error("data frame beat without timer commands");

    // no frame or status beat is produced while the input side is open
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tready && m_tvalid && m_tready) |=> !m_tvalid)
        else $error("result beat produced while idle");

endmodule

// ----- test/go_back_n_link_control_core_test.sv -----
module go_back_n_link_control_core_test;
    import gbn_pkg::*;

    localparam int MAX_SEQ       = 7;
    localparam int RANDOM_EVENTS = 424;
    localparam int PHASE_EVENTS  = 160;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RUN_LIMIT     = 400000;

    // Event and frame-kind codes the package leaves unnamed
    localparam logic [2:0] OP_RSVD_LO   = 3'd5;
    localparam logic [2:0] OP_RSVD_HI   = 3'd7;
    localparam logic [1:0] RX_KIND_RSVD = 2'd3;

    // One stimulus event; typed rows carry a hand-written status beat instead of
    // the predicted one
    typedef struct {
        logic [2:0] op;
        logic       good;
        logic [1:0] kind;
        logic [2:0] seq;
        logic [2:0] ack;
        logic       typed;
        logic       exp_ne;
    } stim_row_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic [4:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    go_back_n_link_control_core #(
        .MAX_SEQUENCE(MAX_SEQ)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Link state mirrored by the predictor; sequence space is 3 bits wide, so
    // plain 3-bit arithmetic wraps modulo eight
    logic [2:0] win_low  = '0;
    logic [2:0] nxt_send = '0;
    logic [2:0] exp_seq  = '0;
    logic [2:0] buf_cnt  = '0;
    logic       nak_ok   = 1'b1;
    logic       line_rdy = 1'b0;

    gbn_result_t call_beats[$];   // beats caused by the event being predicted
    gbn_result_t due_cmds[$];     // command beats still owed by the core
    gbn_result_t want;

    stim_row_t   directed_rows[$];
    logic        row_typed = 1'b0;
    logic        row_ne    = 1'b0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int events_sent    = 0;
    int beats_checked  = 0;
    int data_beats     = 0;
    int nak_beats      = 0;
    int deliveries     = 0;
    int mismatches     = 0;

    // True when b lies in the circular span [a, c)
    function automatic logic seq_between(logic [2:0] a, logic [2:0] b, logic [2:0] c);
        return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
    endfunction

    function automatic gbn_result_t status_beat(logic ne, atc_t atc, logic dlv);
        gbn_result_t b;
        b = '0;
        b.send_kind      = KIND_NONE;
        b.ack_timer_cmd  = atc;
        b.deliver_packet = dlv;
        b.network_enable = ne;
        b.last           = 1'b1;
        return b;
    endfunction

    // Queue one frame command; every frame carries the piggybacked ack and
    // stops the ack timer. Drop frames past the per-event cap.
    function automatic void queue_frame(send_kind_t kind, logic [2:0] seq);
        gbn_result_t b;
        if (call_beats.size() >= MAX_FRAMES)
            return;
        b = '0;
        b.send_kind        = kind;
        b.send_seq         = (kind == KIND_DATA) ? seq : 3'd0;
        b.send_ack         = exp_seq - 3'd1;
        b.start_data_timer = (kind == KIND_DATA);
        b.ack_timer_cmd    = ATC_STOP;
        call_beats.push_back(b);
        if (kind == KIND_NAK)
            nak_ok = 1'b0;
        line_rdy = 1'b0;
    endfunction

    // Go back to the window base and resend every buffered frame
    function automatic void resend_window();
        int i;
        nxt_send = win_low;
        for (i = 0; i < buf_cnt; i++) begin
            queue_frame(KIND_DATA, nxt_send);
            nxt_send = nxt_send + 3'd1;
        end
    endfunction

    function automatic void predict_link_event(logic [2:0] op, logic good, logic [1:0] kind,
                                               logic [2:0] fseq, logic [2:0] fack);
        logic [7:0] stopped;
        atc_t       ack_cmd;
        logic       deliver;
        call_beats.delete();
        stopped = '0;
        ack_cmd = ATC_LEAVE;
        deliver = 1'b0;
        case (op)
            OP_PACKET: begin
                if (buf_cnt < MAX_SEQ) begin
                    buf_cnt = buf_cnt + 3'd1;
                    queue_frame(KIND_DATA, nxt_send);
                    nxt_send = nxt_send + 3'd1;
                end
            end
            OP_LINE: begin
                line_rdy = 1'b1;
            end
            OP_FRAME: begin
                if (!good) begin
                    if (nak_ok)
                        queue_frame(KIND_NAK, 3'd0);
                end else begin
                    // release every slot covered by the cumulative ack
                    while (seq_between(win_low, fack, nxt_send)) begin
                        if (buf_cnt != 0)
                            buf_cnt = buf_cnt - 3'd1;
                        stopped[win_low] = 1'b1;
                        win_low = win_low + 3'd1;
                    end
                    if (kind == RX_DATA) begin
                        if (fseq != exp_seq && nak_ok) begin
                            queue_frame(KIND_NAK, 3'd0);
                            ack_cmd = ATC_LEAVE;
                        end else begin
                            ack_cmd = ATC_START;
                        end
                        if (fseq == exp_seq) begin
                            deliver = 1'b1;
                            nak_ok  = 1'b1;
                            exp_seq = exp_seq + 3'd1;
                            ack_cmd = ATC_START;
                        end
                    end else if (kind == RX_NAK &&
                                 seq_between(win_low, fack + 3'd1, nxt_send)) begin
                        resend_window();
                    end
                end
            end
            OP_DATA_TMO: begin
                resend_window();
            end
            OP_ACK_TMO: begin
                queue_frame(KIND_ACK, 3'd0);
            end
            default: begin
            end
        endcase
        call_beats.push_back(status_beat((buf_cnt < MAX_SEQ) && line_rdy, ack_cmd, deliver));
        call_beats[0].stopped_timers = stopped;
    endfunction

    function automatic void add_row(logic [2:0] op, logic good, logic [1:0] kind,
                                    logic [2:0] seq, logic [2:0] ack,
                                    logic typed, logic exp_ne);
        stim_row_t row;
        row.op     = op;
        row.good   = good;
        row.kind   = kind;
        row.seq    = seq;
        row.ack    = ack;
        row.typed  = typed;
        row.exp_ne = exp_ne;
        directed_rows.push_back(row);
    endfunction

    // Mostly well-formed traffic: acks aimed inside the open window, data frames
    // mostly in order, a few bad frames, unknown kinds and unknown events
    function automatic stim_row_t random_event();
        stim_row_t row;
        int        pick;
        row.typed  = 1'b0;
        row.exp_ne = 1'b0;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            row.op = OP_PACKET;
        else if (pick < 40)
            row.op = OP_LINE;
        else if (pick < 80)
            row.op = OP_FRAME;
        else if (pick < 88)
            row.op = OP_DATA_TMO;
        else if (pick < 96)
            row.op = OP_ACK_TMO;
        else
            row.op = 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
        row.good = ($urandom_range(0, 99) < 88);
        pick = $urandom_range(0, 99);
        if (pick < 45)
            row.kind = RX_DATA;
        else if (pick < 75)
            row.kind = RX_ACK;
        else if (pick < 93)
            row.kind = RX_NAK;
        else
            row.kind = RX_KIND_RSVD;
        row.seq = ($urandom_range(0, 99) < 60) ? exp_seq : 3'($urandom_range(0, 7));
        if (buf_cnt != 0 && $urandom_range(0, 99) < 70)
            row.ack = win_low - 3'd1 + 3'($urandom_range(0, buf_cnt));
        else
            row.ack = 3'($urandom_range(0, 7));
        return row;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("mismatch at beat %0d: %s = 0x%0h, expected 0x%0h",
                 beats_checked, what, got, exp_val);
        mismatches++;
    endtask

    task automatic check_field(input string what, input int got, input int exp_val);
        if (got != exp_val)
            report_mismatch(what, got, exp_val);
    endtask

    // Drive one event beat at the falling edge; pick idling from the phase the
    // run is in, then hold the beat until the core takes it.
    task automatic drive_event(input stim_row_t row);
        if (events_sent < PHASE_EVENTS) begin
            send_idle_pct  = 25;
            recv_stall_pct = 50;
        end else if (events_sent < 2 * PHASE_EVENTS) begin
            send_idle_pct  = 50;
            recv_stall_pct = 25;
        end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do
                @(negedge aclk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        row_typed = row.typed;
        row_ne    = row.exp_ne;
        s_tvalid <= 1'b1;
        s_tuser  <= {row.kind, row.op};
        s_tdata  <= {1'b0, row.ack, row.seq, row.good};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        events_sent++;
        @(negedge aclk);
    endtask

    // Stall the result side at random, one decision per falling edge
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Check result beats against the oldest owed command, then capture any
    // accepted event beat and predict what it owes.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (due_cmds.size() == 0) begin
                    report_mismatch("beat with nothing owed, send_kind", m_tuser, 0);
                end else begin
                    want = due_cmds.pop_front();
                    check_field("send_kind", m_tuser, want.send_kind);
                    check_field("send_seq", m_tdata[2:0], want.send_seq);
                    check_field("send_ack", m_tdata[5:3], want.send_ack);
                    check_field("start_data_timer", m_tdata[6], want.start_data_timer);
                    check_field("stopped_timers", m_tdata[14:7], want.stopped_timers);
                    check_field("ack_timer_cmd", m_tdata[16:15], want.ack_timer_cmd);
                    check_field("deliver_packet", m_tdata[17], want.deliver_packet);
                    check_field("network_enable", m_tdata[18], want.network_enable);
                    check_field("tdata pad", m_tdata[23:19], 0);
                    check_field("last", m_tlast, want.last);
                    if (want.send_kind == KIND_DATA)
                        data_beats++;
                    if (want.send_kind == KIND_NAK)
                        nak_beats++;
                    if (want.deliver_packet)
                        deliveries++;
                end
                beats_checked++;
            end
            if (s_tvalid && s_tready) begin
                // advance the predicted state even when the row's beat is typed
                predict_link_event(s_tuser[2:0], s_tdata[0], s_tuser[4:3], s_tdata[3:1],
                                   s_tdata[6:4]);
                if (row_typed)
                    due_cmds.push_back(status_beat(row_ne, ATC_LEAVE, 1'b0));
                else
                    foreach (call_beats[i])
                        due_cmds.push_back(call_beats[i]);
            end
        end
    end

    initial begin
        int i;
        int n_directed;

        // unknown event straight after reset: status only, line not ready
        add_row(OP_RSVD_HI, 1'b0, RX_DATA, 3'd0, 3'd0, 1'b1, 1'b0);
        add_row(OP_LINE, 1'b0, RX_DATA, 3'd0, 3'd0, 1'b1, 1'b1);
        // good ack with an empty window releases nothing
        add_row(OP_FRAME, 1'b1, RX_ACK, 3'd0, 3'd0, 1'b1, 1'b1);
        add_row(OP_ACK_TMO, 1'b0, RX_DATA, 3'd0, 3'd0, 1'b0, 1'b0);
        // fill the window, then one more packet is dropped
        for (i = 0; i < MAX_SEQ; i++)
            add_row(OP_PACKET, 1'b0, RX_DATA, 3'd0, 3'd0, 1'b0, 1'b0);
        add_row(OP_PACKET, 1'b0, RX_DATA, 3'd0, 3'd0, 1'b1, 1'b0);
        // full-window retransmission, by timeout and by an in-window nak
        add_row(OP_DATA_TMO, 1'b0, RX_DATA, 3'd0, 3'd0, 1'b0, 1'b0);
        add_row(OP_LINE, 1'b0, RX_DATA, 3'd0, 3'd0, 1'b0, 1'b0);
        add_row(OP_FRAME, 1'b1, RX_NAK, 3'd0, 3'd7, 1'b0, 1'b0);
        add_row(OP_FRAME, 1'b1, RX_ACK, 3'd0, 3'd2, 1'b0, 1'b0);
        // bad frames: first sends a nak, second is silent
        add_row(OP_FRAME, 1'b0, RX_DATA, 3'd0, 3'd0, 1'b0, 1'b0);
        add_row(OP_FRAME, 1'b0, RX_NAK, 3'd7, 3'd7, 1'b1, 1'b0);
        // in-order delivery, then out-of-order with and without a nak
        add_row(OP_FRAME, 1'b1, RX_DATA, 3'd0, 3'd2, 1'b0, 1'b0);
        add_row(OP_FRAME, 1'b1, RX_DATA, 3'd5, 3'd2, 1'b0, 1'b0);
        add_row(OP_FRAME, 1'b1, RX_DATA, 3'd7, 3'd2, 1'b0, 1'b0);
        // unknown frame kind: cumulative ack only, empties the window
        add_row(OP_FRAME, 1'b1, RX_KIND_RSVD, 3'd7, 3'd6, 1'b0, 1'b0);
        add_row(OP_RSVD_LO, 1'b1, RX_DATA, 3'd0, 3'd0, 1'b0, 1'b0);
        add_row(OP_DATA_TMO, 1'b0, RX_DATA, 3'd0, 3'd0, 1'b0, 1'b0);
        add_row(OP_FRAME, 1'b1, RX_NAK, 3'd0, 3'd0, 1'b0, 1'b0);
        add_row(OP_FRAME, 1'b1, RX_DATA, 3'd1, 3'd7, 1'b0, 1'b0);
        n_directed = directed_rows.size();

        // hold reset, then release it on a falling edge
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[k])
            drive_event(directed_rows[k]);
        for (i = 0; i < RANDOM_EVENTS; i++)
            drive_event(random_event());
        s_tvalid <= 1'b0;

        // drain owed beats, then watch for strays
        while (due_cmds.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d events (%0d directed) across three idle/stall phases",
                 events_sent, n_directed);
        $display("checked %0d result beats: %0d data, %0d nak, %0d deliveries",
                 beats_checked, data_beats, nak_beats, deliveries);
        if (mismatches == 0) begin
            $display("go_back_n_link_control_core verification clean");
        end else begin
            $display("go_back_n_link_control_core verification failed");
        end
        $finish;
    end

    // Bound the run in case the core hangs
    initial begin
        #RUN_LIMIT;
        $display("go_back_n_link_control_core verification failed");
        $finish;
    end

endmodule
